FILE: design/stream_find_and_replace_core_defines.svh
// ----------------------------------------------------------------------------
// stream_find_and_replace_core_defines
// assertion macros shared by the find-and-replace checker
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr assertion failed");

// next-cycle implication, disabled during reset
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr assertion failed");

`endif

FILE: design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, constants and helpers of the stream find-and-replace block
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int SFR_MAX_PATTERN     = 8;
   localparam int SFR_MAX_REPLACEMENT = 8;
   localparam int SFR_BYTE_W          = 8;
   localparam int SFR_CSR_INDEX_W     = 2;

   typedef logic [SFR_BYTE_W-1:0]      byte_type;
   typedef logic [SFR_CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PATTERN_BYTES      = 2'd0;
   localparam csr_index_type CSR_PATTERN_LENGTH     = 2'd1;
   localparam csr_index_type CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam csr_index_type CSR_REPLACEMENT_LENGTH = 2'd3;

   // window control from the sequencer
   typedef struct packed {
      logic wr;
      logic shift;
   } win_ctrl_type;

   // byte sel of a 64-bit register, first byte in bits 7:0
   function automatic byte_type byte_at(input logic [63:0] word, input logic [2:0] sel);
      byte_at = word[{sel, 3'b000} +: SFR_BYTE_W];
   endfunction

endpackage

`default_nettype wire

FILE: design/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window
// holding window: write at the fill point, shift out at the head, an indexed read port and a head port
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_window
   import sfr_pkg::*;
#(
   parameter int DEPTH = SFR_MAX_PATTERN
) (
   input  wire                     clock,
   input  win_ctrl_type            ctrl,
   input  wire [$clog2(DEPTH)-1:0] wr_idx,
   input  byte_type                wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_idx,
   output byte_type                rd_data,
   output byte_type                head_data
);

   byte_type win_ff [DEPTH];
   byte_type win_in [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.wr) begin
         win_in[wr_idx] = wr_data;
      end else if (ctrl.shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   assign rd_data   = win_ff[rd_idx];
   assign head_data = win_ff[0];

endmodule

`default_nettype wire

FILE: design/stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_core
// leftmost non-overlapping find-and-replace over a byte stream
// ----------------------------------------------------------------------------
// Bytes enter one per transaction and are held in a window until the window
// holds pattern_length bytes. A byte that leaves the window partly filled
// and is not the last keeps the sequencer in idle. A full window is compared
// one byte per cycle on a single shared byte comparator; a match then sends
// replacement_length result bytes, a miss sends the oldest held byte, each
// result going out through the output register. With req_in_last the held
// bytes are flushed one per cycle while rsp_stall allows; the final result
// carries rsp_out_last (an empty marker when nothing else goes out). rsp_stall
// holds results back in the output register, and req_stall stays high until
// the sequencer is back in idle. Writing pattern_length discards the window;
// csr writes belong between items, while nothing is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_core
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN     = SFR_MAX_PATTERN,
   parameter int MAX_REPLACEMENT = SFR_MAX_REPLACEMENT
) (
   input  wire           clock,
   input  wire           reset,
   // input transactions
   input  wire           req_valid,
   output logic          req_stall,
   input  wire [7:0]     req_in_byte,
   input  wire           req_in_last,
   // result transactions
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_out_present,
   output logic          rsp_out_last,
   // register writes
   input  wire           csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  wire [63:0]    csr_data
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = $clog2(MAX_PATTERN);
   localparam int REP_W = $clog2(MAX_REPLACEMENT + 1);
   localparam logic [3:0] PAT_MAX4 = 4'(MAX_PATTERN);
   localparam logic [3:0] REP_MAX4 = 4'(MAX_REPLACEMENT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_REPL,
      S_DROP,
      S_FLUSH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [REP_W-1:0] ridx_ff, ridx_in;
   logic             last_ff, last_in;
   logic             any_ff, any_in;
   logic [63:0]      pat_bytes_ff, pat_bytes_in;
   logic [3:0]       pat_len_ff, pat_len_in;
   logic [63:0]      rep_bytes_ff, rep_bytes_in;
   logic [3:0]       rep_len_ff, rep_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   byte_type         rsp_byte_ff, rsp_byte_in;
   logic             rsp_present_ff, rsp_present_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [3:0]       len4, rep4;
   logic [CNT_W-1:0] len_eff, len_m1, cnt_plus;
   logic [REP_W-1:0] rep_eff, ridx_plus;
   logic             accept, out_free, hit;
   logic             emit, emit_present, emit_last;
   byte_type         emit_byte;
   win_ctrl_type     win_ctrl;
   byte_type         win_rd, win_head;

   // effective lengths after clamping
   always_comb begin
      if (pat_len_ff == 4'd0) begin
         len4 = 4'd1;
      end else if (pat_len_ff > PAT_MAX4) begin
         len4 = PAT_MAX4;
      end else begin
         len4 = pat_len_ff;
      end
      if (rep_len_ff > REP_MAX4) begin
         rep4 = REP_MAX4;
      end else begin
         rep4 = rep_len_ff;
      end
   end

   assign len_eff   = CNT_W'(len4);
   assign len_m1    = len_eff - CNT_W'(1);
   assign rep_eff   = REP_W'(rep4);
   assign cnt_plus  = cnt_ff + CNT_W'(1);
   assign ridx_plus = ridx_ff + REP_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = (win_rd == byte_at(pat_bytes_ff, 3'(idx_ff)));

   sfr_window #(
      .DEPTH(MAX_PATTERN)
   ) u_window (
      .clock    (clock),
      .ctrl     (win_ctrl),
      .wr_idx   (cnt_ff[IDX_W-1:0]),
      .wr_data  (req_in_byte),
      .rd_idx   (idx_ff),
      .rd_data  (win_rd),
      .head_data(win_head)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      ridx_in        = ridx_ff;
      last_in        = last_ff;
      any_in         = any_ff;
      pat_bytes_in   = pat_bytes_ff;
      pat_len_in     = pat_len_ff;
      rep_bytes_in   = rep_bytes_ff;
      rep_len_in     = rep_len_ff;
      emit           = 1'b0;
      emit_byte      = win_head;
      emit_present   = 1'b1;
      emit_last      = 1'b0;
      win_ctrl.wr    = 1'b0;
      win_ctrl.shift = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               win_ctrl.wr = 1'b1;
               cnt_in      = cnt_plus;
               last_in     = req_in_last;
               any_in      = 1'b0;
               idx_in      = '0;
               if (cnt_plus == len_eff) begin
                  state_in = S_CMP;
               end else if (req_in_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_CMP: begin
            if (!hit) begin
               state_in = S_DROP;
            end else if (CNT_W'(idx_ff) == len_m1) begin
               state_in = S_REPL;
               ridx_in  = '0;
               cnt_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_REPL: begin
            if (ridx_ff == rep_eff) begin
               state_in = last_ff ? S_FLUSH : S_IDLE;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_byte = byte_at(rep_bytes_ff, 3'(ridx_ff));
               emit_last = last_ff && (ridx_plus == rep_eff);
               any_in    = 1'b1;
               ridx_in   = ridx_plus;
            end
         end
         S_DROP: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_last      = last_ff && (cnt_ff == CNT_W'(1));
               win_ctrl.shift = 1'b1;
               cnt_in         = cnt_ff - CNT_W'(1);
               any_in         = 1'b1;
               state_in       = last_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (cnt_ff == '0) begin
               if (any_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  // nothing went out for this string: empty end marker
                  emit         = 1'b1;
                  emit_byte    = '0;
                  emit_present = 1'b0;
                  emit_last    = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (out_free) begin
               emit           = 1'b1;
               emit_last      = (cnt_ff == CNT_W'(1));
               win_ctrl.shift = 1'b1;
               cnt_in         = cnt_ff - CNT_W'(1);
               any_in         = 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // the user must write registers only between items; the block does not enforce it
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES: begin
               pat_bytes_in = csr_data;
            end
            CSR_PATTERN_LENGTH: begin
               pat_len_in = csr_data[3:0];
               cnt_in     = '0;
            end
            CSR_REPLACEMENT_BYTES: begin
               rep_bytes_in = csr_data;
            end
            CSR_REPLACEMENT_LENGTH: begin
               rep_len_in = csr_data[3:0];
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in   = emit || (rsp_valid_ff && rsp_stall);
      rsp_byte_in    = emit ? emit_byte : rsp_byte_ff;
      rsp_present_in = emit ? emit_present : rsp_present_ff;
      rsp_last_in    = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pat_bytes_ff <= '0;
         pat_len_ff   <= 4'd1;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pat_bytes_ff <= pat_bytes_in;
         pat_len_ff   <= pat_len_in;
         rep_bytes_ff <= rep_bytes_in;
         rep_len_ff   <= rep_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      ridx_ff        <= ridx_in;
      last_ff        <= last_in;
      any_ff         <= any_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_out_present = rsp_present_ff;
   assign rsp_out_last    = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks of the stream find-and-replace core, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_find_and_replace_core_defines.svh"

module sfr_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       req_in_last,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_out_present,
   input wire       rsp_out_last
);

   // a stalled result transaction holds
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))

   // an empty marker always closes the string
   `SFR_ASSERT_IMP(a_marker_last, clock, reset, rsp_valid && !rsp_out_present,
      rsp_out_last)

   // an empty marker carries a zero byte
   `SFR_ASSERT_IMP(a_marker_zero, clock, reset, rsp_valid && !rsp_out_present,
      rsp_out_byte == 8'd0)

   // the last byte of a string always produces work, so input is held off
   `SFR_ASSERT_NEXT(a_last_busy, clock, reset,
      req_valid && !req_stall && req_in_last, req_stall)

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (.*);

`default_nettype wire

FILE: tb/sv/stream_find_and_replace_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_core_tb
// self-checking bench for the streaming find-and-replace core
// ----------------------------------------------------------------------------
// Text bytes are pushed through the core under several register settings.
// A behavioral replacer tracks the window and the registers, builds the
// output text for every accepted byte, and the monitor compares each result
// transaction with the oldest owed one. Both sides idle in random bursts. One
// phase holds results back for a long stretch, and some strings wait for the
// output to drain before their first byte goes out.
// ----------------------------------------------------------------------------

module stream_find_and_replace_core_tb;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   typedef enum int {PAT_RANDOM, PAT_AB, PAT_ZERO, PAT_ONES} pat_style_type;

   typedef struct {
      byte_type text;
      logic     last;
      logic     drain_first;
   } text_in_type;

   typedef struct {
      byte_type text;
      logic     present;
      logic     last;
   } text_out_type;

   logic          clock;
   logic          reset           = 1'b1;
   logic          req_valid       = 1'b0;
   logic          req_stall;
   logic [7:0]    req_in_byte     = 8'h00;
   logic          req_in_last     = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall       = 1'b0;
   logic [7:0]    rsp_out_byte;
   logic          rsp_out_present;
   logic          rsp_out_last;
   logic          csr_valid       = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index       = CSR_PATTERN_BYTES;
   logic [63:0]   csr_data        = 64'h0;

   // replacer state, kept apart from the core
   logic [63:0]   pat_word;
   logic [3:0]    pat_len;
   logic [63:0]   rep_word;
   logic [3:0]    rep_len;
   byte_type      window_q[$];

   text_in_type   pending_text[$];
   text_out_type  owed_text[$];
   int            items_queued    = 0;
   int            items_taken     = 0;
   int            results_seen    = 0;
   int            mismatches      = 0;
   int            cycle_count;
   logic          results_idle    = 1'b1;
   logic          quiet           = 1'b0;
   logic          long_hold       = 1'b0;
   logic          hold_served     = 1'b0;
   int            send_gap;
   int            stall_run;
   int            hold_run;

   stream_find_and_replace_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_present (rsp_out_present),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch on result %0d: %s got %0h want %0h",
               results_seen, what, got, want);
   endtask

   // output text owed for one accepted byte
   function automatic void replace_step(input byte_type b, input logic fin);
      int           plen;
      int           rlen;
      int           owed_before;
      bit           hit;
      text_out_type r;
      plen = (pat_len == 0) ? 1 : (pat_len > SFR_MAX_PATTERN) ? SFR_MAX_PATTERN : pat_len;
      rlen = (rep_len > SFR_MAX_REPLACEMENT) ? SFR_MAX_REPLACEMENT : rep_len;
      owed_before = owed_text.size();
      r.present = 1'b1;
      r.last = 1'b0;
      while (window_q.size() > plen - 1) void'(window_q.pop_back());
      window_q.push_back(b);
      if (window_q.size() == plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++) begin
            if (window_q[i] != pat_word[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (int i = 0; i < rlen; i++) begin
               r.text = rep_word[8*i +: 8];
               owed_text.push_back(r);
            end
            window_q.delete();
         end else begin
            r.text = window_q.pop_front();
            owed_text.push_back(r);
         end
      end
      if (fin) begin
         while (window_q.size() > 0) begin
            r.text = window_q.pop_front();
            owed_text.push_back(r);
         end
         // nothing went out for this string end, so an empty marker carries it
         if (owed_text.size() == owed_before) begin
            r.text = 8'h00;
            r.present = 1'b0;
            owed_text.push_back(r);
         end
         r = owed_text.pop_back();
         r.last = 1'b1;
         owed_text.push_back(r);
      end
   endfunction

   // replacer, register mirror and result checks
   always @(posedge clock) begin
      text_out_type want_r;
      if (reset) begin
         pat_word = 64'h0;
         pat_len = 4'd1;
         rep_word = 64'h0;
         rep_len = 4'd0;
         window_q.delete();
         owed_text.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_BYTES: pat_word = csr_data;
               CSR_PATTERN_LENGTH: begin
                  pat_len = csr_data[3:0];
                  window_q.delete();
               end
               CSR_REPLACEMENT_BYTES: rep_word = csr_data;
               CSR_REPLACEMENT_LENGTH: rep_len = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            replace_step(req_in_byte, req_in_last);
            items_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (owed_text.size() == 0) begin
               report_mismatch("result with nothing owed, byte", rsp_out_byte, 0);
            end else begin
               want_r = owed_text.pop_front();
               if (rsp_out_byte !== want_r.text)
                  report_mismatch("out_byte", rsp_out_byte, want_r.text);
               if (rsp_out_present !== want_r.present)
                  report_mismatch("out_present", rsp_out_present, want_r.present);
               if (rsp_out_last !== want_r.last)
                  report_mismatch("out_last", rsp_out_last, want_r.last);
            end
         end
      end
      results_idle <= (owed_text.size() == 0);
   end

   // input transactions from the pending queue
   always @(posedge clock) begin
      text_in_type next_item;
      logic        taken;
      logic        offering;
      if (reset) begin
         send_gap = 0;
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         offering = req_valid && !taken;
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_text.size() > 0 &&
                         !(pending_text[0].drain_first && (taken || !results_idle))) begin
               if (!quiet && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 11);
               end else begin
                  next_item = pending_text.pop_front();
                  req_in_byte <= next_item.text;
                  req_in_last <= next_item.last;
                  offering = 1'b1;
               end
            end
         end
         req_valid <= offering;
      end
   end

   // result side backpressure
   always @(posedge clock) begin
      if (reset) begin
         stall_run = 0;
         hold_run = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold && !hold_served) begin
            hold_run = LONG_HOLD;
            hold_served = 1'b1;
         end
         if (hold_run > 0) begin
            hold_run--;
            rsp_stall <= 1'b1;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge only
   task automatic push_text(input byte_type b, input logic last, input logic drain_first);
      text_in_type item;
      item.text = b;
      item.last = last;
      item.drain_first = drain_first;
      pending_text.push_back(item);
      items_queued++;
   endtask

   // called at a rising edge; valid stays high across back-to-back writes
   task automatic cfg_write(input csr_index_type idx, input logic [63:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_all(input logic [63:0] pw, input logic [3:0] pl,
                            input logic [63:0] rw, input logic [3:0] rl);
      @(posedge clock);
      cfg_write(CSR_PATTERN_BYTES, pw);
      cfg_write(CSR_PATTERN_LENGTH, {60'h0, pl});
      cfg_write(CSR_REPLACEMENT_BYTES, rw);
      cfg_write(CSR_REPLACEMENT_LENGTH, {60'h0, rl});
      csr_valid <= 1'b0;
   endtask

   // every byte taken and every owed result seen, then let the core settle
   task automatic wait_drained();
      do @(negedge clock); while (items_taken != items_queued || owed_text.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [3:0] plen_raw, input logic [3:0] rlen_raw,
                            input pat_style_type style, input int n_items);
      logic [63:0] pw;
      logic [63:0] rw;
      byte_type    text[$];
      int          plen;
      int          made;
      int          len;
      int          cut;
      int          sel;
      logic        hold_first;
      pw = {$urandom, $urandom};
      rw = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
         case (style)
            PAT_AB:   pw[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            PAT_ZERO: pw[8*i +: 8] = 8'h00;
            PAT_ONES: pw[8*i +: 8] = 8'hFF;
            default:  ;
         endcase
      end
      plen = (plen_raw == 0) ? 1 : (plen_raw > SFR_MAX_PATTERN) ? SFR_MAX_PATTERN : plen_raw;
      write_all(pw, plen_raw, rw, rlen_raw);
      @(negedge clock);
      made = 0;
      while (made < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         text.delete();
         // mostly whole or partial pattern copies, with some noise between
         while (text.size() < len) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  for (int i = 0; i < plen; i++) text.push_back(pw[8*i +: 8]);
               end
               4, 5: begin
                  cut = $urandom_range(1, plen);
                  for (int i = 0; i < cut; i++) text.push_back(pw[8*i +: 8]);
               end
               6, 7: begin
                  sel = $urandom_range(0, plen - 1);
                  text.push_back(pw[8*sel +: 8]);
               end
               8: begin
                  sel = $urandom_range(0, 7);
                  text.push_back(rw[8*sel +: 8]);
               end
               default: text.push_back(byte_type'($urandom_range(0, 255)));
            endcase
         end
         hold_first = ($urandom_range(0, 9) == 0);
         foreach (text[j]) push_text(text[j], j == text.size() - 1, hold_first && j == 0);
         made += text.size();
      end
      wait_drained();
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset registers delete every zero byte; a lone match ends in an empty marker
      push_text(8'h00, 1'b1, 1'b0);
      push_text(8'hFF, 1'b0, 1'b0);
      push_text(8'h00, 1'b1, 1'b0);
      wait_drained();

      // longest replacement, then the held tail flushed at the string end
      write_all(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 64'h8877_6655_4433_2211, 4'd8);
      @(negedge clock);
      repeat (4) push_text(8'hFF, 1'b0, 1'b0);
      push_text(8'hFF, 1'b1, 1'b0);
      push_text(8'h7F, 1'b1, 1'b0);
      wait_drained();

      // zero pattern length acts as one, oversized replacement length as eight
      write_all(64'h41, 4'd0, 64'h00FF_00FF_00FF_00FF, 4'd15);
      @(negedge clock);
      push_text(8'h41, 1'b1, 1'b0);
      push_text(8'h42, 1'b0, 1'b0);
      push_text(8'h41, 1'b1, 1'b0);
      wait_drained();

      // oversized pattern length; the half-filled window is dropped by the rewrite
      write_all(64'h6867_6665_6463_6261, 4'd12, 64'h0, 4'd0);
      @(negedge clock);
      push_text(8'h61, 1'b0, 1'b0);
      push_text(8'h62, 1'b0, 1'b0);
      push_text(8'h63, 1'b0, 1'b0);
      wait_drained();
      write_all(64'h7978, 4'd2, 64'h5A, 4'd1);
      @(negedge clock);
      push_text(8'h78, 1'b0, 1'b0);
      push_text(8'h79, 1'b0, 1'b0);
      push_text(8'h78, 1'b1, 1'b0);
      wait_drained();

      run_phase(4'd2, 4'd3, PAT_AB, 50);
      run_phase(4'd8, 4'd8, PAT_RANDOM, 50);
      // results held back while the sender keeps going
      long_hold = 1'b1;
      run_phase(4'd1, 4'd8, PAT_RANDOM, 50);
      run_phase(4'd4, 4'd0, PAT_AB, 50);
      run_phase(4'd0, 4'd15, PAT_ONES, 40);
      run_phase(4'd13, 4'd1, PAT_ZERO, 50);
      run_phase(4'd3, 4'd9, PAT_AB, 50);
      quiet = 1'b1;
      run_phase(4'd5, 4'd2, PAT_RANDOM, 60);

      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
